// ===== rtl/core/kvt_pkg.sv =====
package kvt_pkg;

    // Line limits
    localparam int MAX_KEY   = 32;
    localparam int MAX_VALUE = 128;
    localparam int MAX_LINE  = 256;

    // Counter widths: each holds its limit minus one
    localparam int KEY_W = $clog2(MAX_KEY);
    localparam int VAL_W = $clog2(MAX_VALUE);
    localparam int POS_W = $clog2(MAX_LINE);

    // Largest count that each counter may reach
    localparam int KEY_LIMIT = MAX_KEY - 1;
    localparam int VAL_LIMIT = MAX_VALUE - 1;
    localparam int POS_LIMIT = MAX_LINE - 1;
    localparam logic [KEY_W-1:0] KEY_LAST = KEY_LIMIT[KEY_W-1:0];
    localparam logic [VAL_W-1:0] VAL_LAST = VAL_LIMIT[VAL_W-1:0];
    localparam logic [POS_W-1:0] POS_LAST = POS_LIMIT[POS_W-1:0];

    // Fixed character codes
    localparam logic [7:0] EQ_CHAR      = 8'h3D;
    localparam logic [7:0] QUOTE_CHAR   = 8'h22;
    localparam logic [7:0] NUL_CHAR     = 8'h00;
    localparam logic [7:0] COMMENT_INIT = 8'h23;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_KEY    = 2'd0,
        KIND_VALUE  = 2'd1,
        KIND_STATUS = 2'd2
    } token_kind_t;

    // Line status codes
    typedef enum logic [1:0] {
        ST_PAIR_OK = 2'd0,
        ST_BLANK   = 2'd1,
        ST_ERROR   = 2'd2
    } line_status_t;

    // One input word
    typedef struct packed {
        logic [7:0] char_in;
        logic       line_end;
    } item_t;

    // One result word
    typedef struct packed {
        token_kind_t  token_kind;
        logic [7:0]   out_byte;
        line_status_t line_status;
    } result_t;

    // Whitespace in the usual C sense: tab to carriage return, and space
    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

endpackage

// ===== rtl/core/kvt_in_reg.sv =====
module kvt_in_reg
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  kvt_pkg::item_t  in_item,
    input  logic            advance,
    output logic            held_valid,
    output kvt_pkg::item_t  held_item
);

    logic           valid_reg;
    kvt_pkg::item_t item_reg;

    // The register frees up in the same cycle that its word moves on
    assign in_ready   = !valid_reg || advance;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ===== rtl/core/kvt_parse_core.sv =====
module kvt_parse_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  kvt_pkg::item_t    item,
    input  logic [7:0]        comment_char,
    output logic              res_valid,
    output kvt_pkg::result_t  res
);

    typedef enum logic [3:0] {
        STG_LEAD_WS  = 4'd0,
        STG_KEY      = 4'd1,
        STG_PRE_EQ   = 4'd2,
        STG_EQUAL    = 4'd3,
        STG_POST_EQ  = 4'd4,
        STG_OPEN_Q   = 4'd5,
        STG_VALUE    = 4'd6,
        STG_CLOSE_Q  = 4'd7,
        STG_TRAIL_WS = 4'd8
    } stage_t;

    // Most stage visits that one character needs before it settles
    localparam int PASSES = 4;

    stage_t                     stage_reg, stage_next;
    logic                       quoted_reg, quoted_next;
    logic [kvt_pkg::KEY_W-1:0]  key_count_reg, key_count_next;
    logic [kvt_pkg::VAL_W-1:0]  value_count_reg, value_count_next;
    logic [kvt_pkg::POS_W-1:0]  position_reg, position_next;
    logic                       failed_reg, failed_next;
    logic                       done_reg, done_next;
    logic                       blank_reg, blank_next;

    // Stepper signals
    stage_t      st;
    logic        q;
    logic        settled;
    logic        step_fail;
    logic        step_key;
    logic        step_value;
    logic [7:0]  c;

    assign c = item.char_in;

    // Walk one character through the stages until it settles.
    always_comb
    begin
        st         = stage_reg;
        q          = quoted_reg;
        settled    = 1'b0;
        step_fail  = 1'b0;
        step_key   = 1'b0;
        step_value = 1'b0;
        for (int p = 0; p < PASSES; p++)
        begin
            if (!settled)
            begin
                unique case (st)
                    STG_LEAD_WS:
                    begin
                        if (kvt_pkg::is_ws(c))
                            settled = 1'b1;
                        else
                            st = STG_KEY;
                    end
                    STG_PRE_EQ:
                    begin
                        if (kvt_pkg::is_ws(c))
                            settled = 1'b1;
                        else
                            st = STG_EQUAL;
                    end
                    STG_POST_EQ:
                    begin
                        if (kvt_pkg::is_ws(c))
                            settled = 1'b1;
                        else
                            st = STG_OPEN_Q;
                    end
                    STG_KEY:
                    begin
                        if (kvt_pkg::is_ws(c) || (c == kvt_pkg::EQ_CHAR))
                            st = STG_PRE_EQ;
                        else
                        begin
                            settled = 1'b1;
                            if (key_count_reg < kvt_pkg::KEY_LAST)
                                step_key = 1'b1;
                            else
                                step_fail = 1'b1;
                        end
                    end
                    STG_EQUAL:
                    begin
                        settled = 1'b1;
                        if (c != kvt_pkg::EQ_CHAR)
                            step_fail = 1'b1;
                        else
                            st = STG_POST_EQ;
                    end
                    STG_OPEN_Q:
                    begin
                        st = STG_VALUE;
                        if (c == kvt_pkg::QUOTE_CHAR)
                        begin
                            q       = 1'b1;
                            settled = 1'b1;
                        end
                    end
                    STG_VALUE:
                    begin
                        if ((!q && kvt_pkg::is_ws(c)) || (q && (c == kvt_pkg::QUOTE_CHAR)))
                            st = STG_CLOSE_Q;
                        else
                        begin
                            settled = 1'b1;
                            if (value_count_reg < kvt_pkg::VAL_LAST)
                                step_value = 1'b1;
                            else
                                step_fail = 1'b1;
                        end
                    end
                    STG_CLOSE_Q:
                    begin
                        st = STG_TRAIL_WS;
                        if (q)
                        begin
                            q       = 1'b0;
                            settled = 1'b1;
                        end
                    end
                    STG_TRAIL_WS:
                    begin
                        settled = 1'b1;
                        if (!kvt_pkg::is_ws(c))
                            step_fail = 1'b1;
                    end
                    default:
                        settled = 1'b1;
                endcase
            end
        end
    end

    // Line state update and the result of the held word.
    always_comb
    begin
        stage_next       = stage_reg;
        quoted_next      = quoted_reg;
        key_count_next   = key_count_reg;
        value_count_next = value_count_reg;
        position_next    = position_reg;
        failed_next      = failed_reg;
        done_next        = done_reg;
        blank_next       = blank_reg;
        res_valid        = 1'b0;
        res.token_kind   = kvt_pkg::KIND_KEY;
        res.out_byte     = 8'h00;
        res.line_status  = kvt_pkg::ST_PAIR_OK;
        if (item.line_end)
        begin
            // End of line: report the status and start afresh.
            res_valid      = 1'b1;
            res.token_kind = kvt_pkg::KIND_STATUS;
            priority if (blank_reg)
                res.line_status = kvt_pkg::ST_BLANK;
            else if (failed_reg || (key_count_reg == '0) || (value_count_reg == '0) || quoted_reg)
                res.line_status = kvt_pkg::ST_ERROR;
            else
                res.line_status = kvt_pkg::ST_PAIR_OK;
            stage_next       = STG_LEAD_WS;
            quoted_next      = 1'b0;
            key_count_next   = '0;
            value_count_next = '0;
            position_next    = '0;
            failed_next      = 1'b0;
            done_next        = 1'b0;
            blank_next       = 1'b1;
        end
        else if (position_reg < kvt_pkg::POS_LAST)
        begin
            position_next = position_reg + 1'b1;
            if (!failed_reg && !done_reg)
            begin
                if ((c == kvt_pkg::NUL_CHAR) || ((c == comment_char) && !quoted_reg))
                    done_next = 1'b1;
                else
                begin
                    if (!kvt_pkg::is_ws(c))
                        blank_next = 1'b0;
                    stage_next  = st;
                    quoted_next = q;
                    if (step_fail)
                        failed_next = 1'b1;
                    if (step_key)
                    begin
                        key_count_next = key_count_reg + 1'b1;
                        res_valid      = 1'b1;
                        res.token_kind = kvt_pkg::KIND_KEY;
                        res.out_byte   = c;
                    end
                    if (step_value)
                    begin
                        value_count_next = value_count_reg + 1'b1;
                        res_valid        = 1'b1;
                        res.token_kind   = kvt_pkg::KIND_VALUE;
                        res.out_byte     = c;
                    end
                end
            end
        end
    end

    // Line state registers move on with each processed word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg       <= STG_LEAD_WS;
            quoted_reg      <= 1'b0;
            key_count_reg   <= '0;
            value_count_reg <= '0;
            position_reg    <= '0;
            failed_reg      <= 1'b0;
            done_reg        <= 1'b0;
            blank_reg       <= 1'b1;
        end
        else if (advance)
        begin
            stage_reg       <= stage_next;
            quoted_reg      <= quoted_next;
            key_count_reg   <= key_count_next;
            value_count_reg <= value_count_next;
            position_reg    <= position_next;
            failed_reg      <= failed_next;
            done_reg        <= done_next;
            blank_reg       <= blank_next;
        end
    end

endmodule

// ===== rtl/core/kvt_out_reg.sv =====
module kvt_out_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  kvt_pkg::result_t  load_res,
    output logic              out_ready,
    output logic              out_valid,
    input  logic              out_taken,
    output kvt_pkg::result_t  out_res
);

    logic             valid_reg;
    kvt_pkg::result_t res_reg;

    // A new result may enter when the register is empty or being emptied
    assign out_ready = !valid_reg || out_taken;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_taken)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= load_res;
        end
    end

endmodule

// ===== rtl/core/key_value_line_tokenizer.sv =====
// Channel    Direction  Word contents
// s_axis     in         tdata[7:0] char_in, tlast line_end
// m_axis     out        tdata[7:0] out_byte, tdata[9:8] line_status, tuser[1:0] token_kind
// cfg        in         cfg_wr_data[7:0] comment_char, written when cfg_wr_en is high
//
// Each word waits in the input register until the result register can take its result;
// a word that gives a result has it loaded into the result register, which offers it
// on m_axis. One word is taken every cycle while the result register is not stalled.
// The character step between the two registers is combinational.
// Reset (rst_n, asynchronous) empties both registers, clears the line state and sets
// the comment character to '#'. A stalled result register holds the input register,
// which in turn drops s_axis_tready; nothing is lost or repeated.
module key_value_line_tokenizer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [9:8] line_status, rest zero
    output logic [1:0]  m_axis_tuser,   // [1:0] token_kind
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data
);

    logic             held_valid;
    kvt_pkg::item_t   in_item;
    kvt_pkg::item_t   held_item;
    logic             out_ready;
    logic             advance;
    logic             res_valid;
    kvt_pkg::result_t res;
    kvt_pkg::result_t out_res;
    logic [7:0]       comment_char_reg;

    // Comment character register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comment_char_reg <= kvt_pkg::COMMENT_INIT;
        end
        else if (cfg_wr_en)
        begin
            comment_char_reg <= cfg_wr_data;
        end
    end

    // A held word is processed whenever the result register can take a result
    assign advance = held_valid && out_ready;

    assign in_item.char_in  = s_axis_tdata;
    assign in_item.line_end = s_axis_tlast;

    kvt_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    kvt_parse_core u_parse_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .item         (held_item),
        .comment_char (comment_char_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    kvt_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && res_valid),
        .load_res  (res),
        .out_ready (out_ready),
        .out_valid (m_axis_tvalid),
        .out_taken (m_axis_tready),
        .out_res   (out_res)
    );

    // Pack the result word
    assign m_axis_tdata = {6'd0, out_res.line_status, out_res.out_byte};
    assign m_axis_tuser = out_res.token_kind;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import kvt_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int PHASE_WORDS   = 50;
    localparam int PHASES        = 6;
    localparam int HOLD_CYCLES   = 300;

    // Stages of the line parser as the checker tracks them.
    typedef enum logic [3:0] {
        STG_LEAD_WS     = 4'd0,
        STG_KEY         = 4'd1,
        STG_PRE_EQ_WS   = 4'd2,
        STG_EQUAL       = 4'd3,
        STG_POST_EQ_WS  = 4'd4,
        STG_OPEN_QUOTE  = 4'd5,
        STG_VALUE       = 4'd6,
        STG_CLOSE_QUOTE = 4'd7,
        STG_TRAIL_WS    = 4'd8
    } parse_stage_t;

    // Shapes of generated lines.
    typedef enum logic [2:0] {
        LINE_PAIR,
        LINE_BROKEN,
        LINE_BLANK,
        LINE_NOISE,
        LINE_LONG,
        LINE_OVERSIZE
    } line_kind_t;

    // One row of the directed table: a word and, where given, its result.
    typedef struct packed {
        logic [7:0] ch;
        logic       le;
        logic       typed;
        result_t    want;
    } stim_row_t;

    localparam result_t NO_RESULT = '{KIND_KEY, 8'h00, ST_PAIR_OK};
    localparam int DIRECTED_ROWS = 26;

    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        // Empty line straight after reset.
        '{8'h00, 1'b1, 1'b1, '{KIND_STATUS, 8'h00, ST_BLANK}},
        // k ="v " with a space inside the quotes.
        '{8'h6B, 1'b0, 1'b1, '{KIND_KEY, 8'h6B, ST_PAIR_OK}},
        '{8'h20, 1'b0, 1'b0, NO_RESULT},
        '{8'h3D, 1'b0, 1'b0, NO_RESULT},
        '{8'h22, 1'b0, 1'b0, NO_RESULT},
        '{8'h76, 1'b0, 1'b0, NO_RESULT},
        '{8'h20, 1'b0, 1'b0, NO_RESULT},
        '{8'h22, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, 1'b1, '{KIND_STATUS, 8'h00, ST_PAIR_OK}},
        // Comment-only line.
        '{8'h23, 1'b0, 1'b0, NO_RESULT},
        '{8'h78, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, 1'b1, '{KIND_STATUS, 8'h00, ST_BLANK}},
        // Top byte as a key, then a missing equals sign.
        '{8'hFF, 1'b0, 1'b1, '{KIND_KEY, 8'hFF, ST_PAIR_OK}},
        '{8'h20, 1'b0, 1'b0, NO_RESULT},
        '{8'h7A, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b1, 1'b1, '{KIND_STATUS, 8'h00, ST_ERROR}},
        // Empty key followed by trailing junk.
        '{8'h3D, 1'b0, 1'b0, NO_RESULT},
        '{8'h62, 1'b0, 1'b0, NO_RESULT},
        '{8'h20, 1'b0, 1'b0, NO_RESULT},
        '{8'h63, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, 1'b1, '{KIND_STATUS, 8'h00, ST_ERROR}},
        // A zero byte inside an open quote leaves it unterminated.
        '{8'h61, 1'b0, 1'b0, NO_RESULT},
        '{8'h3D, 1'b0, 1'b0, NO_RESULT},
        '{8'h22, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, 1'b1, '{KIND_STATUS, 8'h00, ST_ERROR}}
    };

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_wr_en     = 1'b0;
    logic [7:0]  cfg_wr_data   = 8'h00;

    // Tracked copy of the tokenizer state.
    logic [7:0]   tk_comment;
    parse_stage_t tk_stage;
    logic         tk_quoted;
    logic [5:0]   tk_key_cnt;
    logic [7:0]   tk_val_cnt;
    logic [8:0]   tk_pos;
    logic         tk_failed;
    logic         tk_done;
    logic         tk_blank;

    result_t    expected_tokens [$];
    logic [7:0] line_chars [$];

    int error_count   = 0;
    int cycle_count   = 0;
    int words_sent    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_token   = 0;
    int stall_seen    = 0;

    key_value_line_tokenizer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Whitespace as the C library sees it.
    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    task automatic clear_line_state();
        tk_stage   = STG_LEAD_WS;
        tk_quoted  = 1'b0;
        tk_key_cnt = '0;
        tk_val_cnt = '0;
        tk_pos     = '0;
        tk_failed  = 1'b0;
        tk_done    = 1'b0;
        tk_blank   = 1'b1;
    endtask

    // Advances the tracked state by one accepted word and gives its result, if any.
    task automatic predict_token(input logic [7:0] c, input logic le,
                                 output bit produced, output result_t res);
        bit settled;
        produced = 1'b0;
        res      = NO_RESULT;
        settled  = 1'b0;
        if (le)
        begin
            produced = 1'b1;
            res.token_kind = KIND_STATUS;
            if (tk_blank)
                res.line_status = ST_BLANK;
            else if (tk_failed || tk_key_cnt == 0 || tk_val_cnt == 0 || tk_quoted)
                res.line_status = ST_ERROR;
            else
                res.line_status = ST_PAIR_OK;
            clear_line_state();
        end
        else if (tk_pos < MAX_LINE - 1)
        begin
            tk_pos++;
            if (!tk_failed && !tk_done)
            begin
                if (c == NUL_CHAR || (c == tk_comment && !tk_quoted))
                    tk_done = 1'b1;
                else
                begin
                    if (!is_space(c))
                        tk_blank = 1'b0;
                    // A character may pass through several stages before it settles.
                    for (int g = 0; g < 12 && !settled; g++)
                    begin
                        case (tk_stage)
                            STG_LEAD_WS, STG_PRE_EQ_WS, STG_POST_EQ_WS:
                            begin
                                if (is_space(c))
                                    settled = 1'b1;
                                else
                                    tk_stage = parse_stage_t'(tk_stage + 4'd1);
                            end
                            STG_KEY:
                            begin
                                if (is_space(c) || c == EQ_CHAR)
                                    tk_stage = STG_PRE_EQ_WS;
                                else
                                begin
                                    settled = 1'b1;
                                    if (tk_key_cnt < MAX_KEY - 1)
                                    begin
                                        tk_key_cnt++;
                                        produced = 1'b1;
                                        res.token_kind = KIND_KEY;
                                        res.out_byte = c;
                                    end
                                    else
                                        tk_failed = 1'b1;
                                end
                            end
                            STG_EQUAL:
                            begin
                                settled = 1'b1;
                                if (c != EQ_CHAR)
                                    tk_failed = 1'b1;
                                else
                                    tk_stage = STG_POST_EQ_WS;
                            end
                            STG_OPEN_QUOTE:
                            begin
                                tk_stage = STG_VALUE;
                                if (c == QUOTE_CHAR)
                                begin
                                    tk_quoted = 1'b1;
                                    settled = 1'b1;
                                end
                            end
                            STG_VALUE:
                            begin
                                if ((!tk_quoted && is_space(c)) || (tk_quoted && c == QUOTE_CHAR))
                                    tk_stage = STG_CLOSE_QUOTE;
                                else
                                begin
                                    settled = 1'b1;
                                    if (tk_val_cnt < MAX_VALUE - 1)
                                    begin
                                        tk_val_cnt++;
                                        produced = 1'b1;
                                        res.token_kind = KIND_VALUE;
                                        res.out_byte = c;
                                    end
                                    else
                                        tk_failed = 1'b1;
                                end
                            end
                            STG_CLOSE_QUOTE:
                            begin
                                tk_stage = STG_TRAIL_WS;
                                if (tk_quoted)
                                begin
                                    tk_quoted = 1'b0;
                                    settled = 1'b1;
                                end
                            end
                            STG_TRAIL_WS:
                            begin
                                settled = 1'b1;
                                if (!is_space(c))
                                    tk_failed = 1'b1;
                            end
                            default:
                                settled = 1'b1;
                        endcase
                    end
                end
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        $display("mismatch at %0t ns: %s got 0x%0h expected 0x%0h", $time, what, got_v, want_v);
        error_count++;
    endtask

    // Offers one word, waits for it to be taken and records what it should cause.
    task automatic send_word(input logic [7:0] c, input logic le,
                             input logic typed, input result_t want);
        bit      produced;
        result_t res;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= le;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_token(c, le, produced, res);
        if (typed)
            expected_tokens.push_back(want);
        else if (produced)
            expected_tokens.push_back(res);
        words_sent++;
    endtask

    // Lets every expected word arrive and the pipeline empty.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_comment_char(input logic [7:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        tk_comment = v;
    endtask

    function automatic logic [7:0] pick_space();
        int v;
        v = $urandom_range(8, 13);
        return (v == 8) ? 8'h20 : 8'(v);
    endfunction

    function automatic logic [7:0] pick_key_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (is_space(c) || c == EQ_CHAR || c == tk_comment);
        return c;
    endfunction

    function automatic logic [7:0] pick_value_char(input logic q);
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (q ? (c == QUOTE_CHAR)
                 : (is_space(c) || c == tk_comment || c == QUOTE_CHAR));
        return c;
    endfunction

    function automatic line_kind_t pick_line_kind();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60)
            return LINE_PAIR;
        else if (p < 72)
            return LINE_BROKEN;
        else if (p < 82)
            return LINE_BLANK;
        else if (p < 92)
            return LINE_NOISE;
        else if (p < 94)
            return LINE_LONG;
        else
            return LINE_OVERSIZE;
    endfunction

    task automatic add_spaces(input int most);
        repeat ($urandom_range(0, most)) line_chars.push_back(pick_space());
    endtask

    // Fills line_chars with the characters of one line of the given shape.
    task automatic build_line(input line_kind_t kind);
        int klen;
        int vlen;
        int idx;
        int target;
        logic q;
        line_chars.delete();
        case (kind)
            LINE_PAIR, LINE_BROKEN, LINE_OVERSIZE:
            begin
                klen = $urandom_range(1, 8);
                vlen = $urandom_range(1, 10);
                if (kind == LINE_OVERSIZE)
                begin
                    if ($urandom_range(0, 1))
                        klen = $urandom_range(MAX_KEY - 2, MAX_KEY + 2);
                    else
                        vlen = $urandom_range(MAX_VALUE - 2, MAX_VALUE + 2);
                end
                q = 1'($urandom_range(0, 1));
                add_spaces(2);
                repeat (klen) line_chars.push_back(pick_key_char());
                add_spaces(2);
                line_chars.push_back(EQ_CHAR);
                add_spaces(2);
                if (q)
                    line_chars.push_back(QUOTE_CHAR);
                repeat (vlen) line_chars.push_back(pick_value_char(q));
                if (q)
                    line_chars.push_back(QUOTE_CHAR);
                add_spaces(2);
                if ($urandom_range(0, 3) == 0)
                begin
                    line_chars.push_back(tk_comment);
                    repeat ($urandom_range(0, 6)) line_chars.push_back(8'($urandom_range(0, 255)));
                end
                // Break an otherwise good line in one of several ways.
                if (kind == LINE_BROKEN)
                begin
                    idx = $urandom_range(0, line_chars.size() - 1);
                    case ($urandom_range(0, 3))
                        0: line_chars.delete(idx);
                        1: line_chars.insert(idx, 8'($urandom_range(0, 255)));
                        2:
                        begin
                            line_chars.push_back(pick_space());
                            line_chars.push_back(pick_key_char());
                        end
                        default:
                            while (line_chars.size() > idx)
                                void'(line_chars.pop_back());
                    endcase
                end
            end
            LINE_BLANK:
            begin
                add_spaces(4);
                if ($urandom_range(0, 1))
                begin
                    line_chars.push_back(tk_comment);
                    repeat ($urandom_range(0, 6)) line_chars.push_back(8'($urandom_range(0, 255)));
                end
            end
            LINE_NOISE:
                repeat ($urandom_range(0, 20)) line_chars.push_back(8'($urandom_range(0, 255)));
            default:
            begin
                // A pair padded out to the line limit, then one junk character
                // that lands just inside or just beyond it.
                line_chars.push_back(pick_key_char());
                line_chars.push_back(EQ_CHAR);
                repeat ($urandom_range(1, 100)) line_chars.push_back(pick_value_char(1'b0));
                target = MAX_LINE - 3 + $urandom_range(0, 4);
                while (line_chars.size() < target)
                    line_chars.push_back(8'h20);
                line_chars.push_back(pick_key_char());
            end
        endcase
    endtask

    task automatic send_line();
        foreach (line_chars[i])
            send_word(line_chars[i], 1'b0, 1'b0, NO_RESULT);
        send_word(8'($urandom_range(0, 255)), 1'b1, 1'b0, NO_RESULT);
    endtask

    // Receiver: random back-pressure, with one long hold-off on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (stall_token != stall_seen)
            begin
                stall_seen = stall_token;
                m_axis_tready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(posedge clk);
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Every word taken from the output is checked against the oldest expectation.
    always @(posedge clk)
    begin : token_check
        result_t      want;
        token_kind_t  got_kind;
        line_status_t got_status;
        logic [7:0]   got_byte;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_kind   = token_kind_t'(m_axis_tuser);
            got_byte   = m_axis_tdata[7:0];
            got_status = line_status_t'(m_axis_tdata[9:8]);
            if (expected_tokens.size() == 0)
                report_mismatch("unexpected word, kind", got_kind, 0);
            else
            begin
                want = expected_tokens.pop_front();
                if (got_kind != want.token_kind)
                    report_mismatch("token_kind", got_kind, want.token_kind);
                if (got_byte != want.out_byte)
                    report_mismatch("out_byte", got_byte, want.out_byte);
                if (got_status != want.line_status)
                    report_mismatch("line_status", got_status, want.line_status);
            end
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("DONE: errors detected");
        $finish;
    end

    // Main sequence: reset, directed table, then random phases.
    initial
    begin
        logic [7:0] comment_plan [PHASES];
        comment_plan = '{COMMENT_INIT, 8'h3B, 8'h00, 8'hFF, 8'h20, 8'h00};
        comment_plan[PHASES - 1] = 8'($urandom_range(0, 255));
        tk_comment = COMMENT_INIT;
        clear_line_state();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 10;
        recv_idle_pct = 88;
        foreach (DIRECTED[i])
            send_word(DIRECTED[i].ch, DIRECTED[i].le, DIRECTED[i].typed, DIRECTED[i].want);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            int phase_start;
            wait_drained();
            write_comment_char(comment_plan[ph]);
            if (ph < 2)
            begin
                send_idle_pct = 10;
                recv_idle_pct = 88;
            end
            else if (ph < 4)
            begin
                send_idle_pct = 88;
                recv_idle_pct = 10;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // Hold the receiver off while the sender keeps pushing.
            if (ph == 4)
                stall_token++;
            phase_start = words_sent;
            if (ph == 2)
            begin
                build_line(LINE_LONG);
                send_line();
            end
            while (words_sent - phase_start < PHASE_WORDS)
            begin
                build_line(pick_line_kind());
                send_line();
            end
        end

        wait_drained();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
